@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers clocked on aclk; ASSERT_CLK is masked by aresetn.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, masked while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/core/qte_pkg.sv @@
// ----------------------------------------------------------------------------
// qte_pkg
// Widths, constants and the arctangent table of the quaternion to Euler block.
// ----------------------------------------------------------------------------
package qte_pkg;

    parameter int ANGLE_ITERATIONS_DEF = 24;

    parameter int Q_W    = 32;   // input component width
    parameter int PROD_W = 35;   // Q30 product after the floor shift
    parameter int SUM_W  = 40;   // sums and CORDIC vector
    parameter int ANG_W  = 36;   // Q30 angle accumulator
    parameter int SQ_W   = 63;   // integer square root operand
    parameter int SQRT_STEPS = 32;
    parameter int MUL_W  = 50;   // angle times degree scale
    parameter int DEG_W  = 20;   // scaled angle before saturation

    parameter logic signed [SUM_W-1:0] ONE_Q30 = 40'sd1073741824;
    parameter logic signed [ANG_W-1:0] PI_Q30  = 36'sd3373259426;
    parameter logic signed [MUL_W-1:0] DEG100_PER_RAD = 50'sd5730;
    parameter logic signed [MUL_W-1:0] HALF_Q30 = 50'sd536870912;
    parameter logic signed [DEG_W-1:0] PITCH_LIM = 20'sd9002;
    parameter logic signed [DEG_W-1:0] ANGLE_LIM = 20'sd18004;

    // Q30 product, floor rounded
    function automatic logic signed [PROD_W-1:0] mul_q30(
        input logic signed [Q_W-1:0] a,
        input logic signed [Q_W-1:0] b
    );
        logic signed [2*Q_W-1:0] p;
        p = a * b;
        return {p[2*Q_W-1], p[2*Q_W-1:30]};
    endfunction

    // atan(2^-i) in Q30
    function automatic logic signed [ANG_W-1:0] atan_tab(input int unsigned idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:  v = 36'sh03243F6A8;
            1:  v = 36'sh01DAC6705;
            2:  v = 36'sh00FADBAFC;
            3:  v = 36'sh007F56EA6;
            4:  v = 36'sh003FEAB76;
            5:  v = 36'sh001FFD55B;
            6:  v = 36'sh000FFFAAA;
            7:  v = 36'sh0007FFF55;
            8:  v = 36'sh0003FFFEA;
            9:  v = 36'sh0001FFFFD;
            10: v = 36'sh0000FFFFF;
            11: v = 36'sh00007FFFF;
            12: v = 36'sh00003FFFF;
            13: v = 36'sh00001FFFF;
            14: v = 36'sh00000FFFF;
            15: v = 36'sh000007FFF;
            16: v = 36'sh000003FFF;
            17: v = 36'sh000001FFF;
            18: v = 36'sh000000FFF;
            19: v = 36'sh0000007FF;
            20: v = 36'sh0000003FF;
            21: v = 36'sh0000001FF;
            22: v = 36'sh0000000FF;
            23: v = 36'sh00000007F;
            24: v = 36'sh00000003F;
            25: v = 36'sh00000001F;
            26: v = 36'sh00000000F;
            27: v = 36'sh000000008;
            28: v = 36'sh000000004;
            29: v = 36'sh000000002;
            30: v = 36'sh000000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/quaternion_to_euler_angles.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Attitude quaternion (Q30) to ZYX pitch, roll and yaw in 0.01 degree.
// ----------------------------------------------------------------------------
// One request in, one request out, fully pipelined: a new quaternion can be
// taken every cycle unless the pipe is held, and results leave in order. The
// stages are one product stage, one sum/saturate stage, one square stage, 32
// square-root stages (one result bit each, needed for the pitch cosine), one
// quadrant fold stage, ANGLE_ITERATIONS CORDIC stages, one scale multiply and
// the output register. The whole pipe advances together; it holds only
// while the output register has a result that the sink has not taken.
// Pitch uses asin clamped to +-90 degrees; angles are scaled by 57.3
// degrees per radian and rounded to nearest.
// No normalization is done on the input quaternion.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_to_euler_angles
    import qte_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata: quat_w [31:0], quat_x [63:32], quat_y [95:64], quat_z [127:96]
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,
    // m_tdata: pitch_angle [14:0], roll_angle [30:15], yaw_angle [46:31], pad [47]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata
);

    localparam int NIT = ANGLE_ITERATIONS;

    logic en;   // whole pipe advances

    logic m_valid_reg;
    logic [47:0] m_data_reg;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------------------------------------------------------- products
    logic signed [Q_W-1:0] qw, qx, qy, qz;
    assign qw = s_tdata[31:0];
    assign qx = s_tdata[63:32];
    assign qy = s_tdata[95:64];
    assign qz = s_tdata[127:96];

    logic v_p_reg;
    logic signed [PROD_W-1:0] p_wy_reg, p_xz_reg, p_yz_reg, p_wx_reg, p_xx_reg;
    logic signed [PROD_W-1:0] p_yy_reg, p_xy_reg, p_wz_reg, p_ww_reg, p_zz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_p_reg <= 1'b0;
        end else if (en) begin
            v_p_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_wy_reg <= mul_q30(qw, qy);
            p_xz_reg <= mul_q30(qx, qz);
            p_yz_reg <= mul_q30(qy, qz);
            p_wx_reg <= mul_q30(qw, qx);
            p_xx_reg <= mul_q30(qx, qx);
            p_yy_reg <= mul_q30(qy, qy);
            p_xy_reg <= mul_q30(qx, qy);
            p_wz_reg <= mul_q30(qw, qz);
            p_ww_reg <= mul_q30(qw, qw);
            p_zz_reg <= mul_q30(qz, qz);
        end
    end

    // ---------------------------------------------------------------- sums
    logic signed [SUM_W-1:0] s_full, rn_next, rd_next, yn_next, yd_next;
    logic signed [Q_W-1:0]   s_next;

    always_comb begin
        s_full  = (SUM_W'(p_wy_reg) - SUM_W'(p_xz_reg)) <<< 1;
        rn_next = (SUM_W'(p_yz_reg) + SUM_W'(p_wx_reg)) <<< 1;
        rd_next = ONE_Q30 - ((SUM_W'(p_xx_reg) + SUM_W'(p_yy_reg)) <<< 1);
        yn_next = (SUM_W'(p_xy_reg) + SUM_W'(p_wz_reg)) <<< 1;
        yd_next = SUM_W'(p_ww_reg) + SUM_W'(p_xx_reg) - SUM_W'(p_yy_reg)
                  - SUM_W'(p_zz_reg);
        // asin argument clamped to +-1
        if (s_full > ONE_Q30) begin
            s_next = Q_W'(ONE_Q30);
        end else if (s_full < -ONE_Q30) begin
            s_next = Q_W'(-ONE_Q30);
        end else begin
            s_next = Q_W'(s_full);
        end
    end

    logic v_s_reg;
    logic signed [Q_W-1:0]   s_reg;
    logic signed [SUM_W-1:0] rn_reg, rd_reg, yn_reg, yd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_s_reg <= 1'b0;
        end else if (en) begin
            v_s_reg <= v_p_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg  <= s_next;
            rn_reg <= rn_next;
            rd_reg <= rd_next;
            yn_reg <= yn_next;
            yd_reg <= yd_next;
        end
    end

    // ---------------------------------------------------------------- sqrt
    // cos(pitch) = floor(sqrt(2^60 - s^2)), one result bit per stage
    logic                    v_sq_reg  [0:SQRT_STEPS];
    logic [SQ_W-1:0]         sq_n_reg  [0:SQRT_STEPS];
    logic [SQ_W-1:0]         sq_r_reg  [0:SQRT_STEPS];
    logic signed [Q_W-1:0]   sq_s_reg  [0:SQRT_STEPS];
    logic signed [SUM_W-1:0] sq_rn_reg [0:SQRT_STEPS];
    logic signed [SUM_W-1:0] sq_rd_reg [0:SQRT_STEPS];
    logic signed [SUM_W-1:0] sq_yn_reg [0:SQRT_STEPS];
    logic signed [SUM_W-1:0] sq_yd_reg [0:SQRT_STEPS];

    logic signed [2*Q_W-1:0] s_sq;
    assign s_sq = s_reg * s_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_sq_reg[0] <= 1'b0;
        end else if (en) begin
            v_sq_reg[0] <= v_s_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_n_reg[0]  <= SQ_W'(64'h1000_0000_0000_0000 - s_sq);
            sq_r_reg[0]  <= '0;
            sq_s_reg[0]  <= s_reg;
            sq_rn_reg[0] <= rn_reg;
            sq_rd_reg[0] <= rd_reg;
            sq_yn_reg[0] <= yn_reg;
            sq_yd_reg[0] <= yd_reg;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 1 - 2 * k);
        logic [SQ_W-1:0] trial, n_next, r_next;

        always_comb begin
            trial = sq_r_reg[k] + BIT;
            if (sq_n_reg[k] >= trial) begin
                n_next = sq_n_reg[k] - trial;
                r_next = (sq_r_reg[k] >> 1) + BIT;
            end else begin
                n_next = sq_n_reg[k];
                r_next = sq_r_reg[k] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_sq_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_sq_reg[k+1] <= v_sq_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_n_reg[k+1]  <= n_next;
                sq_r_reg[k+1]  <= r_next;
                sq_s_reg[k+1]  <= sq_s_reg[k];
                sq_rn_reg[k+1] <= sq_rn_reg[k];
                sq_rd_reg[k+1] <= sq_rd_reg[k];
                sq_yn_reg[k+1] <= sq_yn_reg[k];
                sq_yd_reg[k+1] <= sq_yd_reg[k];
            end
        end
    end

    // ---------------------------------------------------------------- CORDIC
    // lane 0 pitch, lane 1 roll, lane 2 yaw
    logic signed [SUM_W-1:0] ax [0:2];
    logic signed [SUM_W-1:0] ay [0:2];

    assign ax[0] = SUM_W'(sq_r_reg[SQRT_STEPS][30:0]);
    assign ay[0] = SUM_W'(sq_s_reg[SQRT_STEPS]);
    assign ax[1] = sq_rd_reg[SQRT_STEPS];
    assign ay[1] = sq_rn_reg[SQRT_STEPS];
    assign ax[2] = sq_yd_reg[SQRT_STEPS];
    assign ay[2] = sq_yn_reg[SQRT_STEPS];

    logic                    v_c_reg  [0:NIT];
    logic signed [SUM_W-1:0] cx_reg   [0:2][0:NIT];
    logic signed [SUM_W-1:0] cy_reg   [0:2][0:NIT];
    logic signed [ANG_W-1:0] cz_reg   [0:2][0:NIT];
    logic                    czero_reg[0:2][0:NIT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_c_reg[0] <= 1'b0;
        end else if (en) begin
            v_c_reg[0] <= v_sq_reg[SQRT_STEPS];
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_lane
        // fold left half plane by +-pi; zero vector flagged
        always_ff @(posedge aclk) begin
            if (en) begin
                czero_reg[a][0] <= (ax[a] == '0) && (ay[a] == '0);
                if (ax[a] < 0) begin
                    cx_reg[a][0] <= -ax[a];
                    cy_reg[a][0] <= -ay[a];
                    cz_reg[a][0] <= (ay[a] >= 0) ? PI_Q30 : -PI_Q30;
                end else begin
                    cx_reg[a][0] <= ax[a];
                    cy_reg[a][0] <= ay[a];
                    cz_reg[a][0] <= '0;
                end
            end
        end

        for (genvar i = 0; i < NIT; i++) begin : g_iter
            logic signed [SUM_W-1:0] dx, dy;
            logic signed [ANG_W-1:0] da;

            assign dx = cy_reg[a][i] >>> (i % SUM_W);
            assign dy = cx_reg[a][i] >>> (i % SUM_W);
            assign da = atan_tab(i);

            always_ff @(posedge aclk) begin
                if (en) begin
                    czero_reg[a][i+1] <= czero_reg[a][i];
                    if (cy_reg[a][i] >= 0) begin
                        cx_reg[a][i+1] <= cx_reg[a][i] + dx;
                        cy_reg[a][i+1] <= cy_reg[a][i] - dy;
                        cz_reg[a][i+1] <= cz_reg[a][i] + da;
                    end else begin
                        cx_reg[a][i+1] <= cx_reg[a][i] - dx;
                        cy_reg[a][i+1] <= cy_reg[a][i] + dy;
                        cz_reg[a][i+1] <= cz_reg[a][i] - da;
                    end
                end
            end
        end
    end

    for (genvar i = 0; i < NIT; i++) begin : g_cvalid
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_c_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_c_reg[i+1] <= v_c_reg[i];
            end
        end
    end

    // ---------------------------------------------------------------- scale
    logic v_m_reg;
    logic signed [MUL_W-1:0] mul_reg [0:2];
    logic signed [DEG_W-1:0] deg     [0:2];
    logic signed [DEG_W-1:0] lim     [0:2];
    logic signed [DEG_W-1:0] sat     [0:2];

    assign lim[0] = PITCH_LIM;
    assign lim[1] = ANGLE_LIM;
    assign lim[2] = ANGLE_LIM;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_m_reg <= 1'b0;
        end else if (en) begin
            v_m_reg <= v_c_reg[NIT];
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_scale
        logic signed [MUL_W-1:0] rounded;

        always_ff @(posedge aclk) begin
            if (en) begin
                mul_reg[a] <= czero_reg[a][NIT] ? '0
                            : MUL_W'(cz_reg[a][NIT]) * DEG100_PER_RAD;
            end
        end

        always_comb begin
            rounded = (mul_reg[a] + HALF_Q30) >>> 30;
            deg[a]  = DEG_W'(rounded);
            if (deg[a] > lim[a]) begin
                sat[a] = lim[a];
            end else if (deg[a] < -lim[a]) begin
                sat[a] = -lim[a];
            end else begin
                sat[a] = deg[a];
            end
        end
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v_m_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= {1'b0, sat[2][15:0], sat[1][15:0], sat[0][14:0]};
        end
    end

    // ---------------------------------------------------------------- checks
    logic pitch_ok, roll_ok;
    assign pitch_ok = ($signed(m_tdata[14:0]) <= 15'sd9002)
                   && ($signed(m_tdata[14:0]) >= -15'sd9002);
    assign roll_ok  = ($signed(m_tdata[30:15]) <= 16'sd18004)
                   && ($signed(m_tdata[30:15]) >= -16'sd18004);

    `ASSERT_CLK(a_pitch_range, m_tvalid |-> pitch_ok, "pitch out of range")
    `ASSERT_CLK(a_roll_range, m_tvalid |-> roll_ok, "roll out of range")
    `ASSERT_CLK(a_stall_holds, !s_tready |=> m_tvalid, "result dropped during stall")
    `ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule
